// ----- design/plu_pkg.sv -----
// ----------------------------------------------------------------------------
// plu_pkg: shared types and helpers for the packed lane saturating ALU
// Operation codes and the signed word-to-byte saturation used when packing.
// ----------------------------------------------------------------------------
package plu_pkg;

    // Operation codes
    typedef enum logic [2:0] {
        OP_PMULHW   = 3'd0,
        OP_PSRAW    = 3'd1,
        OP_PSLLW    = 3'd2,
        OP_PADDSW   = 3'd3,
        OP_PADDUSB  = 3'd4,
        OP_PSUBUSB  = 3'd5,
        OP_PSUBUSW  = 3'd6,
        OP_PACKSSWB = 3'd7
    } t_op;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LANE_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 6;

    localparam logic [LANE_W-1:0] S16_MAX = 16'h7fff;
    localparam logic [LANE_W-1:0] S16_MIN = 16'h8000;
    localparam logic [BYTE_W-1:0] S8_MAX  = 8'h7f;
    localparam logic [BYTE_W-1:0] S8_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] U8_MAX  = 8'hff;

    // Saturate a signed 16-bit word into a signed byte
    function automatic logic [BYTE_W-1:0] sat_s16_to_s8(input logic [LANE_W-1:0] v);
        logic [BYTE_W-1:0] res;
        if (!v[15] && (v[14:7] != 8'h00)) begin
            res = S8_MAX;
        end else if (v[15] && (v[14:7] != 8'hff)) begin
            res = S8_MIN;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

// ----- design/plu_lane16.sv -----
// ----------------------------------------------------------------------------
// plu_lane16: one 16-bit lane of the packed ALU
// Multiply-high, shifts, signed saturating add and unsigned saturating
// subtract on a single word lane.
// ----------------------------------------------------------------------------
module plu_lane16
    import plu_pkg::*;
(
    input  t_op               i_op,
    input  logic [LANE_W-1:0] i_x,
    input  logic [LANE_W-1:0] i_y,
    input  logic [CNT_W-1:0]  i_cnt,
    output logic [LANE_W-1:0] o_res
);

    logic signed [2*LANE_W-1:0] product;
    logic        [3:0]          sra_cnt;
    logic signed [LANE_W-1:0]   sra_res;
    logic        [LANE_W-1:0]   sll_res;
    logic signed [LANE_W:0]     sum;
    logic        [LANE_W-1:0]   add_res;
    logic        [LANE_W-1:0]   sub_res;

    // Signed product, keep the high half
    assign product = $signed(i_x) * $signed(i_y);

    // Clamp the arithmetic shift count to 15
    assign sra_cnt = (i_cnt > 6'd15) ? 4'd15 : i_cnt[3:0];
    assign sra_res = $signed(i_x) >>> sra_cnt;

    // Logical left shift, zero once the count reaches the lane width
    assign sll_res = (i_cnt[5:4] != 2'b00) ? '0 : (i_x << i_cnt[3:0]);

    // Signed saturating add
    assign sum = {i_x[15], i_x} + {i_y[15], i_y};
    always_comb begin
        if (sum[16] != sum[15]) begin
            add_res = sum[16] ? S16_MIN : S16_MAX;
        end else begin
            add_res = sum[15:0];
        end
    end

    // Unsigned subtract, floor at zero
    assign sub_res = (i_x > i_y) ? (i_x - i_y) : '0;

    // Select the lane result
    always_comb begin
        unique case (i_op)
            OP_PMULHW: o_res = product[2*LANE_W-1:LANE_W];
            OP_PSRAW:  o_res = sra_res;
            OP_PSLLW:  o_res = sll_res;
            OP_PADDSW: o_res = add_res;
            default:   o_res = sub_res;
        endcase
    end

endmodule

// ----- design/plu_byte.sv -----
// ----------------------------------------------------------------------------
// plu_byte: one 8-bit lane of the packed ALU
// Unsigned saturating add and subtract on a single byte lane.
// ----------------------------------------------------------------------------
module plu_byte
    import plu_pkg::*;
(
    input  t_op               i_op,
    input  logic [BYTE_W-1:0] i_x,
    input  logic [BYTE_W-1:0] i_y,
    output logic [BYTE_W-1:0] o_res
);

    logic [BYTE_W:0]   sum;
    logic [BYTE_W-1:0] add_res;
    logic [BYTE_W-1:0] sub_res;

    // Clamp the add at 255
    assign sum     = {1'b0, i_x} + {1'b0, i_y};
    assign add_res = sum[BYTE_W] ? U8_MAX : sum[BYTE_W-1:0];

    // Floor the subtract at zero
    assign sub_res = (i_x > i_y) ? (i_x - i_y) : '0;

    assign o_res = (i_op == OP_PSUBUSB) ? sub_res : add_res;

endmodule

// ----- design/packed_lane_saturating_alu.sv -----
// Flow: a request accepted into the input register moves on to the result register,
//   whose valid flag drives o_valid; i_stall can hold it in either register.
// Throughput: one request per cycle while the output is not stalled; the input and result
//   registers each advance whenever the stage after them is empty or being drained.
// Reset: synchronous, active low; clears both stage valid flags, payload is not cleared.
// The block holds no state between requests.
// ----------------------------------------------------------------------------
// packed_lane_saturating_alu: two-stage packed integer ALU
// Registers the request, computes the packed 16-bit or 8-bit lane result in
// one pass of lane logic, and holds it in a result register.
// ----------------------------------------------------------------------------
module packed_lane_saturating_alu
    import plu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_operation,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_packed_result
);

    logic              r_in_valid;
    t_op               r_op;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_result;
    logic [WORD_W-1:0] n_result;

    logic              out_open;
    logic              in_open;

    logic [LANE_W-1:0] lane_lo;
    logic [LANE_W-1:0] lane_hi;
    logic [WORD_W-1:0] byte_res;
    logic [WORD_W-1:0] pack_res;

    // Stage flow control
    assign out_open = !r_out_valid || !i_stall;
    assign in_open  = !r_in_valid || out_open;
    assign o_stall  = !in_open;

    // Hold stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_open) begin
                r_in_valid <= i_valid;
            end
            if (out_open) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Capture request and result payload
    always_ff @(posedge i_clk) begin
        if (in_open && i_valid) begin
            r_op <= t_op'(i_operation);
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
        if (out_open && r_in_valid) begin
            r_result <= n_result;
        end
    end

    // Word lanes
    plu_lane16 u_lane_lo (
        .i_op  (r_op),
        .i_x   (r_a[15:0]),
        .i_y   (r_b[15:0]),
        .i_cnt (r_b[CNT_W-1:0]),
        .o_res (lane_lo)
    );

    plu_lane16 u_lane_hi (
        .i_op  (r_op),
        .i_x   (r_a[31:16]),
        .i_y   (r_b[31:16]),
        .i_cnt (r_b[CNT_W-1:0]),
        .o_res (lane_hi)
    );

    // Byte lanes
    for (genvar k = 0; k < 4; k++) begin : g_byte
        plu_byte u_byte (
            .i_op  (r_op),
            .i_x   (r_a[k*BYTE_W +: BYTE_W]),
            .i_y   (r_b[k*BYTE_W +: BYTE_W]),
            .o_res (byte_res[k*BYTE_W +: BYTE_W])
        );
    end

    // Pack a then b words into signed-saturated bytes
    assign pack_res = {sat_s16_to_s8(r_b[31:16]), sat_s16_to_s8(r_b[15:0]),
                       sat_s16_to_s8(r_a[31:16]), sat_s16_to_s8(r_a[15:0])};

    // Select the packed result
    always_comb begin
        unique case (r_op)
            OP_PADDUSB,
            OP_PSUBUSB:  n_result = byte_res;
            OP_PACKSSWB: n_result = pack_res;
            default:     n_result = {lane_hi, lane_lo};
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_packed_result = r_result;

    // Reset empties the result stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Input stalls only when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // An accepted request lands in the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_valid)
        else $error("accepted request lost");

    // A word left shift by sixteen or more clears the result
    a_sll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_open && r_in_valid && (r_op == OP_PSLLW) && (r_b[5:4] != 2'b00))
        |=> (o_packed_result == '0))
        else $error("wide left shift did not clear the lanes");

endmodule
